// ----- sv/sabt_pkg.sv -----
// Package for the selective acknowledgement bitmap tracker.
// Field widths and the command and status bundles between controller and datapath.
// No dependencies.
package sabt_pkg;

  localparam int SEQ_W   = 32;
  localparam int MAP_W   = 64;
  localparam int S_TDATA_W = SEQ_W;
  localparam int M_TDATA_W = SEQ_W + MAP_W;

  typedef struct packed {
    logic load;
    logic flush_emit;
    logic walk_emit;
    logic shift;
    logic finish;
  } sabt_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic pending;
    logic walk_go;
    logic top_set;
    logic out_free;
  } sabt_status_t;

endpackage

// ----- sv/sabt_ctrl.sv -----
// Controller state machine of the acknowledgement tracker.
// Sequences load, gap walk, emit and finish; depends on sabt_pkg.
module sabt_ctrl
  import sabt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  sabt_status_t status,
  output sabt_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.is_tick) begin
          if (!status.pending) begin
            state_next = ST_IDLE;
          end else if (status.out_free) begin
            cmd.flush_emit = 1'b1;
            state_next     = ST_IDLE;
          end
        end else if (status.walk_go) begin
          if (!status.top_set) begin
            cmd.shift = 1'b1;
          end else if (status.out_free) begin
            cmd.walk_emit = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/sabt_datapath.sv -----
// Datapath of the acknowledgement tracker: sequence and map registers, shifter, output register.
// Driven by sabt_ctrl through sabt_cmd_t; depends on sabt_pkg.
module sabt_datapath
  import sabt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic                 s_tuser,
  input  sabt_cmd_t            cmd,
  output sabt_status_t         status,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tuser
);

  logic [SEQ_W-1:0] next_expected;
  logic [MAP_W-1:0] received_map;
  logic             ack_pending;
  logic             fold;
  logic             is_tick;
  logic [SEQ_W-1:0] seq;
  logic             emit;
  logic [MAP_W-1:0] map_shifted;

  assign emit        = cmd.flush_emit | cmd.walk_emit;
  assign map_shifted = {received_map[MAP_W-2:0], fold};

  assign status.is_tick  = is_tick;
  assign status.pending  = ack_pending;
  assign status.walk_go  = (seq > next_expected) && (fold || (received_map != '0));
  assign status.top_set  = received_map[MAP_W-1];
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_expected <= '0;
      received_map  <= '0;
      ack_pending   <= 1'b0;
      fold          <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.load) begin
        fold <= ack_pending;
      end
      if (cmd.flush_emit) begin
        received_map <= '0;
        ack_pending  <= 1'b0;
      end
      if (cmd.walk_emit) begin
        next_expected <= seq + 1'b1;
        received_map  <= '0;
        ack_pending   <= 1'b1;
        fold          <= 1'b0;
      end
      if (cmd.shift) begin
        next_expected <= next_expected + 1'b1;
        received_map  <= map_shifted;
        fold          <= 1'b0;
      end
      if (cmd.finish) begin
        next_expected <= seq + 1'b1;
        received_map  <= map_shifted;
        ack_pending   <= 1'b1;
        fold          <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seq     <= s_tdata;
      is_tick <= s_tuser;
    end
    if (emit) begin
      m_tdata <= {received_map, next_expected - 1'b1};
      m_tuser <= received_map != '0;
    end
  end

endmodule

// ----- sv/selective_ack_bitmap_tracker.sv -----
// Top level of the selective acknowledgement bitmap tracker.
// Joins sabt_ctrl and sabt_datapath; depends on sabt_pkg.
//
// Accepts one transaction at a time. A data packet is loaded and then walks each missing sequence
// number (one map shift per cycle in the datapath shifter) before it finishes or emits; an idle
// tick flushes any pending acknowledgement. An acknowledgement waits in the output register, and
// the walk holds while a new acknowledgement is due and the previous one has not been taken.
module selective_ack_bitmap_tracker
  import sabt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // seq
  input  logic                 s_tuser,   // cmd
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // ack_number, ack_bits
  output logic                 m_tuser    // bits_present
);

  sabt_cmd_t    cmd;
  sabt_status_t status;

  sabt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sabt_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
